// ===== hdl/lbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbps_pkg
// Shared types, codes and helpers for the LED burst pattern sequencer.
// ----------------------------------------------------------------------------
package lbps_pkg;

  localparam int MS_W    = 16;
  localparam int CODE_W  = 2;
  localparam int IDX_W   = 4;
  localparam int REG_W   = 3;
  localparam int SUM_W   = MS_W + 1;
  localparam int BURST_W = SUM_W + 4;
  localparam int TOTAL_W = BURST_W + 1;

  localparam logic [CODE_W-1:0] FUNC_TICK      = 2'd0;
  localparam logic [CODE_W-1:0] FUNC_SET_STATE = 2'd1;
  localparam logic [CODE_W-1:0] FUNC_FRESET    = 2'd2;

  localparam logic [CODE_W-1:0] DEV_NOPOLL  = 2'd0;
  localparam logic [CODE_W-1:0] DEV_POLLING = 2'd1;
  localparam logic [CODE_W-1:0] DEV_FRESET  = 2'd2;

  localparam logic [CODE_W-1:0] MODE_PATTERN = 2'd0;
  localparam logic [CODE_W-1:0] MODE_ON      = 2'd1;
  localparam logic [CODE_W-1:0] MODE_OFF     = 2'd2;

  localparam logic [REG_W-1:0] REG_LED_MODE   = 3'd0;
  localparam logic [REG_W-1:0] REG_PULSE_ON   = 3'd1;
  localparam logic [REG_W-1:0] REG_PULSE_GAP  = 3'd2;
  localparam logic [REG_W-1:0] REG_NOPOLL_PER = 3'd3;
  localparam logic [REG_W-1:0] REG_POLL_PER   = 3'd4;
  localparam logic [REG_W-1:0] REG_FRESET_PER = 3'd5;

  localparam logic [MS_W-1:0] RST_PULSE_ON   = 16'd50;
  localparam logic [MS_W-1:0] RST_PULSE_GAP  = 16'd150;
  localparam logic [MS_W-1:0] RST_NOPOLL_PER = 16'd3000;
  localparam logic [MS_W-1:0] RST_POLL_PER   = 16'd1500;
  localparam logic [MS_W-1:0] RST_FRESET_PER = 16'd250;

  localparam logic [IDX_W-1:0] PULSES_NOPOLL  = 4'd1;
  localparam logic [IDX_W-1:0] PULSES_POLLING = 4'd2;
  localparam logic [IDX_W-1:0] PULSES_FRESET  = 4'd10;

  typedef struct packed {
    logic [CODE_W-1:0] led_mode;
    logic [MS_W-1:0]   pulse_on_ms;
    logic [MS_W-1:0]   pulse_gap_ms;
    logic [MS_W-1:0]   nopoll_period_ms;
    logic [MS_W-1:0]   polling_period_ms;
    logic [MS_W-1:0]   freset_period_ms;
  } lbps_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] mode;
  } lbps_mode_wr_t;

  typedef struct packed {
    logic [CODE_W-1:0] current_state;
    logic [CODE_W-1:0] pending_state;
    logic [CODE_W-1:0] pattern_select;
    logic [IDX_W-1:0]  pulse_index;
    logic [MS_W-1:0]   phase_timer;
    logic              pulse_lit;
    logic              burst_done;
    logic              fr_once;
    logic              led_level;
  } lbps_state_t;

  function automatic lbps_state_t load_burst(lbps_state_t st, logic [CODE_W-1:0] sel,
                                             logic once);
    lbps_state_t r;
    r                = st;
    r.pulse_index    = '0;
    r.phase_timer    = '0;
    r.pulse_lit      = 1'b0;
    r.burst_done     = 1'b0;
    r.fr_once        = once;
    r.pattern_select = sel;
    r.led_level      = 1'b0;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pulses_of(logic [CODE_W-1:0] sel);
    logic [IDX_W-1:0] p;
    case (sel)
      DEV_POLLING: p = PULSES_POLLING;
      DEV_FRESET:  p = PULSES_FRESET;
      default:     p = PULSES_NOPOLL;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lbps_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbps_cfg_regs
// Configuration register file; flags a mode write that changes the mode.
// ----------------------------------------------------------------------------
module lbps_cfg_regs import lbps_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [REG_W-1:0]   cfg_index,
  input  wire logic [MS_W-1:0]    cfg_wdata,
  output lbps_cfg_t               cfg,
  output lbps_mode_wr_t           mode_wr
);

  lbps_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt       = cfg_r;
    mode_wr.valid = 1'b0;
    mode_wr.mode  = cfg_wdata[CODE_W-1:0];
    if (cfg_we) begin
      case (cfg_index)
        REG_LED_MODE: begin
          cfg_nxt.led_mode = cfg_wdata[CODE_W-1:0];
          mode_wr.valid    = (cfg_wdata[CODE_W-1:0] != cfg_r.led_mode);
        end
        REG_PULSE_ON:   cfg_nxt.pulse_on_ms       = cfg_wdata;
        REG_PULSE_GAP:  cfg_nxt.pulse_gap_ms      = cfg_wdata;
        REG_NOPOLL_PER: cfg_nxt.nopoll_period_ms  = cfg_wdata;
        REG_POLL_PER:   cfg_nxt.polling_period_ms = cfg_wdata;
        REG_FRESET_PER: cfg_nxt.freset_period_ms  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_mode          <= MODE_PATTERN;
      cfg_r.pulse_on_ms       <= RST_PULSE_ON;
      cfg_r.pulse_gap_ms      <= RST_PULSE_GAP;
      cfg_r.nopoll_period_ms  <= RST_NOPOLL_PER;
      cfg_r.polling_period_ms <= RST_POLL_PER;
      cfg_r.freset_period_ms  <= RST_FRESET_PER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hdl/lbps_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbps_step
// Next-state logic: one transaction or one mode change per cycle.
// ----------------------------------------------------------------------------
module lbps_step import lbps_pkg::*; (
  input  lbps_state_t             st,
  input  lbps_cfg_t               cfg,
  input  lbps_mode_wr_t           mode_wr,
  input  wire logic               item_go,
  input  wire logic [CODE_W-1:0]  func,
  input  wire logic [MS_W-1:0]    tick_ms,
  input  wire logic [CODE_W-1:0]  new_state,
  output lbps_state_t             st_nxt
);

  logic [MS_W-1:0]    pt;
  logic [SUM_W-1:0]   pulse_sum;
  logic [BURST_W-1:0] burst_len;
  logic [TOTAL_W-1:0] total;
  logic [MS_W-1:0]    period;
  logic [IDX_W-1:0]   idx_inc;
  logic               pattern_mode;

  always_comb begin
    pt        = st.phase_timer + tick_ms;
    pulse_sum = {1'b0, cfg.pulse_on_ms} + {1'b0, cfg.pulse_gap_ms};
    case (st.pattern_select)
      DEV_POLLING: begin
        burst_len = {3'b0, pulse_sum, 1'b0};
        period    = cfg.polling_period_ms;
      end
      DEV_FRESET: begin
        burst_len = {1'b0, pulse_sum, 3'b0} + {3'b0, pulse_sum, 1'b0};
        period    = cfg.freset_period_ms;
      end
      default: begin
        burst_len = {4'b0, pulse_sum};
        period    = cfg.nopoll_period_ms;
      end
    endcase
    total        = {1'b0, burst_len} + {{(TOTAL_W-MS_W){1'b0}}, pt};
    idx_inc      = st.pulse_index + 4'd1;
    pattern_mode = (cfg.led_mode != MODE_ON) && (cfg.led_mode != MODE_OFF);
  end

  always_comb begin
    st_nxt = st;
    if (mode_wr.valid) begin
      case (mode_wr.mode)
        MODE_ON:  st_nxt.led_level = 1'b1;
        MODE_OFF: st_nxt.led_level = 1'b0;
        default:  st_nxt = load_burst(st, st.current_state, 1'b0);
      endcase
    end else if (item_go) begin
      case (func)
        FUNC_TICK: begin
          if (cfg.led_mode == MODE_ON) begin
            st_nxt.led_level = 1'b1;
          end else if (cfg.led_mode == MODE_OFF && !st.fr_once) begin
            st_nxt.led_level = 1'b0;
          end else if (!st.burst_done) begin
            st_nxt.phase_timer = pt;
            if (st.pulse_lit) begin
              if (pt >= cfg.pulse_on_ms) begin
                st_nxt.led_level   = 1'b0;
                st_nxt.pulse_lit   = 1'b0;
                st_nxt.phase_timer = '0;
                st_nxt.pulse_index = idx_inc;
                st_nxt.burst_done  = (idx_inc >= pulses_of(st.pattern_select));
              end
            end else if (pt >= cfg.pulse_gap_ms) begin
              st_nxt.led_level   = 1'b1;
              st_nxt.pulse_lit   = 1'b1;
              st_nxt.phase_timer = '0;
            end
          end else begin
            st_nxt.phase_timer = pt;
            if (total >= {{(TOTAL_W-MS_W){1'b0}}, period}) begin
              if (st.fr_once) begin
                st_nxt               = load_burst(st, st.pending_state, 1'b0);
                st_nxt.current_state = st.pending_state;
              end else begin
                st_nxt = load_burst(st, st.current_state, 1'b0);
              end
            end
          end
        end
        FUNC_SET_STATE: begin
          if (st.fr_once) begin
            st_nxt.pending_state = new_state;
          end else if (new_state != st.current_state) begin
            st_nxt.current_state = new_state;
            if (pattern_mode) begin
              st_nxt               = load_burst(st, new_state, 1'b0);
              st_nxt.current_state = new_state;
            end
          end
        end
        FUNC_FRESET: begin
          st_nxt               = load_burst(st, DEV_FRESET, 1'b1);
          st_nxt.pending_state = st.current_state;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/led_burst_pattern_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_burst_pattern_sequencer
// Status LED burst sequencer: ticks, state changes and factory-reset one-shot.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Each accepted item is held in
// an input register, applied to the sequencer state by combinational
// compare/add logic, and its result lands in an output register; throughput
// is one item per clock unless the output stalls, and out_valid rises as the
// output register loads. Configuration writes take effect on the clock edge
// they are presented and must only be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module led_burst_pattern_sequencer import lbps_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [CODE_W-1:0]  in_func,
  input  wire logic [MS_W-1:0]    in_tick_ms,
  input  wire logic [CODE_W-1:0]  in_new_state,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic               out_led_on,
  output      logic [CODE_W-1:0]  out_device_state,
  output      logic               out_one_shot_active,
  input  wire logic               cfg_we,
  input  wire logic [REG_W-1:0]   cfg_index,
  input  wire logic [MS_W-1:0]    cfg_wdata
);

  lbps_cfg_t     cfg;
  lbps_mode_wr_t mode_wr;
  lbps_state_t   st_r, st_nxt;

  logic              s1_valid_r;
  logic [CODE_W-1:0] s1_func_r;
  logic [MS_W-1:0]   s1_tick_ms_r;
  logic [CODE_W-1:0] s1_new_state_r;
  logic              out_valid_r;
  logic              out_led_r;
  logic [CODE_W-1:0] out_state_r;
  logic              out_once_r;
  logic              advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  lbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .mode_wr   (mode_wr)
  );

  lbps_step u_step (
    .st        (st_r),
    .cfg       (cfg),
    .mode_wr   (mode_wr),
    .item_go   (advance),
    .func      (s1_func_r),
    .tick_ms   (s1_tick_ms_r),
    .new_state (s1_new_state_r),
    .st_nxt    (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= load_burst('0, DEV_NOPOLL, 1'b0);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func_r      <= in_func;
      s1_tick_ms_r   <= in_tick_ms;
      s1_new_state_r <= in_new_state;
    end
    if (advance) begin
      out_led_r   <= st_nxt.led_level;
      out_state_r <= st_nxt.current_state;
      out_once_r  <= st_nxt.fr_once;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_led_on          = out_led_r;
  assign out_device_state    = out_state_r;
  assign out_one_shot_active = out_once_r;

  a_oneshot_sel: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fr_once |-> (st_r.pattern_select == DEV_FRESET))
    else $error("one-shot running without factory-reset pattern");

  a_done_off: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.burst_done |-> !st_r.pulse_lit)
    else $error("burst done while in on phase");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pulse_index <= PULSES_FRESET)
    else $error("pulse index overran burst length");

  a_mode_on: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !mode_wr.valid && s1_func_r == FUNC_TICK && cfg.led_mode == MODE_ON)
      |=> (out_valid && out_led_on))
    else $error("tick in always-on mode did not light LED");

endmodule
`default_nettype wire

// ===== tb/led_pattern_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pattern_checker
// Tracks the LED sequencer state, predicts each transaction's result and
// compares the results returned by the block, in order, field by field.
// ----------------------------------------------------------------------------
module led_pattern_checker import lbps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CODE_W-1:0] in_func,
  input  logic [MS_W-1:0]   in_tick_ms,
  input  logic [CODE_W-1:0] in_new_state,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_led_on,
  input  logic [CODE_W-1:0] out_device_state,
  input  logic              out_one_shot_active,
  input  logic              cfg_we,
  input  logic [REG_W-1:0]  cfg_index,
  input  logic [MS_W-1:0]   cfg_wdata,
  output int                errors,
  output int                outstanding
);

  typedef struct packed {
    logic              led_on;
    logic [CODE_W-1:0] device_state;
    logic              one_shot_active;
  } led_view_t;

  led_view_t results_due[$];
  int        fail_count;

  logic [CODE_W-1:0] mode_r;
  logic [MS_W-1:0]   on_ms, gap_ms, nopoll_per, poll_per, freset_per;

  logic [CODE_W-1:0] cur_state, held_state, shape;
  logic [IDX_W-1:0]  pulse_no;
  logic [MS_W-1:0]   elapsed;
  logic              lit_phase, idle_phase, once_active, led;

  function automatic int unsigned burst_len(logic [CODE_W-1:0] sel);
    case (sel)
      DEV_POLLING: return PULSES_POLLING;
      DEV_FRESET:  return PULSES_FRESET;
      default:     return PULSES_NOPOLL;
    endcase
  endfunction

  function automatic logic [MS_W-1:0] burst_period(logic [CODE_W-1:0] sel);
    case (sel)
      DEV_POLLING: return poll_per;
      DEV_FRESET:  return freset_per;
      default:     return nopoll_per;
    endcase
  endfunction

  task automatic restart(input logic [CODE_W-1:0] sel, input logic once);
    pulse_no    = '0;
    elapsed     = '0;
    lit_phase   = 1'b0;
    idle_phase  = 1'b0;
    once_active = once;
    shape       = sel;
    led         = 1'b0;
  endtask

  task automatic advance_time(input logic [MS_W-1:0] ms);
    logic [31:0] spent;
    if (mode_r == MODE_ON) begin
      led = 1'b1;
    end else if (mode_r == MODE_OFF && !once_active) begin
      led = 1'b0;
    end else begin
      elapsed = elapsed + ms;
      if (!idle_phase) begin
        if (lit_phase) begin
          if (elapsed >= on_ms) begin
            led       = 1'b0;
            lit_phase = 1'b0;
            elapsed   = '0;
            pulse_no  = pulse_no + 1'b1;
            if (pulse_no >= burst_len(shape))
              idle_phase = 1'b1;
          end
        end else if (elapsed >= gap_ms) begin
          led       = 1'b1;
          lit_phase = 1'b1;
          elapsed   = '0;
        end
      end else begin
        // trailing idle: full-width sum, timer itself wraps at 16 bits
        spent = burst_len(shape) * (32'(on_ms) + 32'(gap_ms)) + 32'(elapsed);
        if (spent >= 32'(burst_period(shape))) begin
          if (once_active) begin
            restart(held_state, 1'b0);
            cur_state = held_state;
          end else begin
            restart(cur_state, 1'b0);
          end
        end
      end
    end
  endtask

  task automatic apply_write(input logic [REG_W-1:0] idx, input logic [MS_W-1:0] data);
    case (idx)
      REG_LED_MODE: begin
        if (data[CODE_W-1:0] != mode_r) begin
          mode_r = data[CODE_W-1:0];
          if (mode_r == MODE_ON)
            led = 1'b1;
          else if (mode_r == MODE_OFF)
            led = 1'b0;
          else
            restart(cur_state, 1'b0);
        end
      end
      REG_PULSE_ON:   on_ms      = data;
      REG_PULSE_GAP:  gap_ms     = data;
      REG_NOPOLL_PER: nopoll_per = data;
      REG_POLL_PER:   poll_per   = data;
      REG_FRESET_PER: freset_per = data;
      default: ;
    endcase
  endtask

  task automatic predict_led(input logic [CODE_W-1:0] func, input logic [MS_W-1:0] ms,
                             input logic [CODE_W-1:0] ns, output led_view_t res);
    case (func)
      FUNC_TICK: advance_time(ms);
      FUNC_SET_STATE: begin
        if (once_active) begin
          held_state = ns;
        end else if (ns != cur_state) begin
          cur_state = ns;
          if (mode_r != MODE_ON && mode_r != MODE_OFF)
            restart(cur_state, 1'b0);
        end
      end
      FUNC_FRESET: begin
        held_state = cur_state;
        restart(DEV_FRESET, 1'b1);
      end
      default: ;
    endcase
    res.led_on          = led;
    res.device_state    = cur_state;
    res.one_shot_active = once_active;
  endtask

  task automatic note_mismatch(input string what, input logic [CODE_W-1:0] exp,
                               input logic [CODE_W-1:0] act);
    fail_count++;
    $display("%0t: %s expected %0d, got %0d", $time, what, exp, act);
  endtask

  always @(posedge clk) begin : watch
    led_view_t want, seen;
    if (!rst_n) begin
      mode_r     = MODE_PATTERN;
      on_ms      = RST_PULSE_ON;
      gap_ms     = RST_PULSE_GAP;
      nopoll_per = RST_NOPOLL_PER;
      poll_per   = RST_POLL_PER;
      freset_per = RST_FRESET_PER;
      cur_state  = DEV_NOPOLL;
      held_state = DEV_NOPOLL;
      restart(DEV_NOPOLL, 1'b0);
      results_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen.led_on          = out_led_on;
        seen.device_state    = out_device_state;
        seen.one_shot_active = out_one_shot_active;
        if (results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result transaction with none expected (led %0b state %0d once %0b)",
                   $time, seen.led_on, seen.device_state, seen.one_shot_active);
        end else begin
          want = results_due.pop_front();
          if (seen.led_on !== want.led_on)
            note_mismatch("led_on", want.led_on, seen.led_on);
          if (seen.device_state !== want.device_state)
            note_mismatch("device_state", want.device_state, seen.device_state);
          if (seen.one_shot_active !== want.one_shot_active)
            note_mismatch("one_shot_active", want.one_shot_active, seen.one_shot_active);
        end
      end
      if (cfg_we)
        apply_write(cfg_index, cfg_wdata);
      if (in_valid && in_ready) begin
        predict_led(in_func, in_tick_ms, in_new_state, want);
        results_due.push_back(want);
      end
    end
    errors      <= fail_count;
    outstanding <= results_due.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the LED burst pattern sequencer: directed ticks, state changes
// and factory-reset bursts, then randomized phases over many register settings
// with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import lbps_pkg::*;

  localparam logic [CODE_W-1:0] FUNC_UNUSED  = 2'd3;
  localparam logic [CODE_W-1:0] MODE_ALIAS   = 2'd3;
  localparam logic [CODE_W-1:0] DEV_UNUSED   = 2'd3;
  localparam logic [REG_W-1:0]  REG_SPARE_LO = 3'd6;
  localparam logic [REG_W-1:0]  REG_SPARE_HI = 3'd7;

  localparam int NUM_PHASES    = 16;
  localparam int PHASE_ITEMS   = 95;
  localparam int HOLD_PHASE    = 7;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 4000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CODE_W-1:0] in_func = FUNC_TICK;
  logic [MS_W-1:0]   in_tick_ms = '0;
  logic [CODE_W-1:0] in_new_state = DEV_NOPOLL;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_led_on;
  logic [CODE_W-1:0] out_device_state;
  logic              out_one_shot_active;
  logic              cfg_we = 1'b0;
  logic [REG_W-1:0]  cfg_index = REG_LED_MODE;
  logic [MS_W-1:0]   cfg_wdata = '0;

  int errors, outstanding;
  int tick_span = 200, freset_permille = 12;
  bit quiet = 1'b0, hold_req = 1'b0;
  int n_tick = 0, n_set = 0, n_freset = 0, n_unused = 0, n_holds = 0;

  always #1 clk = ~clk;

  led_burst_pattern_sequencer dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_func, .in_tick_ms, .in_new_state,
    .out_valid, .out_ready, .out_led_on, .out_device_state, .out_one_shot_active,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  led_pattern_checker chk (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_func, .in_tick_ms, .in_new_state,
    .out_valid, .out_ready, .out_led_on, .out_device_state, .out_one_shot_active,
    .cfg_we, .cfg_index, .cfg_wdata,
    .errors, .outstanding
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_item(input logic [CODE_W-1:0] f, input logic [MS_W-1:0] ms,
                           input logic [CODE_W-1:0] st);
    int g;
    g = quiet ? 0 : idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_tick_ms   <= ms;
    in_new_state <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (f)
      FUNC_TICK:      n_tick++;
      FUNC_SET_STATE: n_set++;
      FUNC_FRESET:    n_freset++;
      default:        n_unused++;
    endcase
  endtask

  task automatic random_item();
    int r;
    logic [CODE_W-1:0] f, st;
    logic [MS_W-1:0] ms;
    r = $urandom_range(0, 999);
    if (r < freset_permille)
      f = FUNC_FRESET;
    else if (r < freset_permille + 20)
      f = FUNC_UNUSED;
    else if (r < freset_permille + 120)
      f = FUNC_SET_STATE;
    else
      f = FUNC_TICK;
    r = $urandom_range(0, 99);
    if (r < 4)
      ms = '0;
    else if (r < 7)
      ms = '1;
    else if (r < 15)
      ms = 16'($urandom_range(0, 65535));
    else
      ms = 16'($urandom_range(0, tick_span));
    r = $urandom_range(0, 9);
    st = (r < 4) ? DEV_NOPOLL : (r < 8) ? DEV_POLLING : (r < 9) ? DEV_FRESET : DEV_UNUSED;
    send_item(f, ms, st);
  endtask

  task automatic settle();
    int n;
    in_valid <= 1'b0;
    @(posedge clk);
    n = 0;
    while (outstanding != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [MS_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_phase(input int ph);
    logic [MS_W-1:0] on_v, gap_v, per0, per1, per2, mode_v;
    int ex;
    ex = ph / 4;
    case (ph % 4)
      0: begin
        on_v  = 16'($urandom_range(0, 8));
        gap_v = 16'($urandom_range(0, 8));
        per0  = 16'($urandom_range(0, 120));
        per1  = 16'($urandom_range(0, 120));
        per2  = 16'($urandom_range(0, 120));
        tick_span = 10;
      end
      1: begin
        on_v  = 16'($urandom_range(1, 50));
        gap_v = 16'($urandom_range(1, 50));
        per0  = 16'($urandom_range(0, 1000));
        per1  = 16'($urandom_range(0, 1000));
        per2  = 16'($urandom_range(0, 1000));
        tick_span = 60;
      end
      2: begin
        on_v  = ex[0] ? 16'hFFFF : 16'd1;
        gap_v = ex[1] ? 16'hFFFF : 16'd1;
        per0  = ex[0] ? 16'hFFFF : 16'd0;
        per1  = ex[1] ? 16'd0 : 16'hFFFF;
        per2  = (ex == 1 || ex == 2) ? 16'hFFFF : 16'd0;
        tick_span = 65535;
      end
      default: begin
        on_v  = 16'($urandom_range(0, 4000));
        gap_v = 16'($urandom_range(0, 4000));
        per0  = 16'($urandom_range(0, 65535));
        per1  = 16'($urandom_range(0, 65535));
        per2  = 16'($urandom_range(0, 65535));
        tick_span = 4000;
      end
    endcase
    case (ph % 6)
      2:       mode_v = {14'd0, MODE_ON};
      3:       mode_v = {14'd0, MODE_OFF};
      4:       mode_v = {14'($urandom_range(1, 16383)), MODE_PATTERN};
      5:       mode_v = {14'd0, MODE_ALIAS};
      default: mode_v = {14'd0, MODE_PATTERN};
    endcase
    write_reg(REG_PULSE_ON, on_v);
    write_reg(REG_PULSE_GAP, gap_v);
    write_reg(REG_NOPOLL_PER, per0);
    write_reg(REG_POLL_PER, per1);
    write_reg(REG_FRESET_PER, per2);
    write_reg(REG_LED_MODE, mode_v);
    if (ph == 5) begin
      write_reg(REG_SPARE_LO, 16'($urandom_range(0, 65535)));
      write_reg(REG_SPARE_HI, 16'($urandom_range(0, 65535)));
    end
    cfg_we <= 1'b0;
    freset_permille = (ph % 3 == 0) ? 50 : 12;
    quiet = (ph == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
  endtask

  // result side: random stalls in segments, plus one long hold-off on request
  initial begin : sink
    int stall, pct, seg;
    stall = 0;
    pct   = 0;
    seg   = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
        n_holds++;
      end else if (stall == 0) begin
        if (seg == 0) begin
          seg = $urandom_range(20, 300);
          pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
        end
        seg--;
        if ($urandom_range(0, 99) < pct)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int ph;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, pattern mode
    send_item(FUNC_TICK, 16'd0, DEV_NOPOLL);
    send_item(FUNC_TICK, 16'd150, DEV_NOPOLL);
    send_item(FUNC_TICK, 16'd50, DEV_NOPOLL);
    send_item(FUNC_TICK, 16'hFFFF, DEV_UNUSED);
    send_item(FUNC_SET_STATE, 16'hFFFF, DEV_POLLING);
    send_item(FUNC_SET_STATE, 16'd0, DEV_POLLING);
    send_item(FUNC_SET_STATE, 16'd0, DEV_UNUSED);
    send_item(FUNC_UNUSED, 16'hFFFF, DEV_UNUSED);
    send_item(FUNC_TICK, 16'd200, DEV_NOPOLL);
    send_item(FUNC_FRESET, 16'hFFFF, DEV_NOPOLL);
    send_item(FUNC_SET_STATE, 16'd0, DEV_POLLING);
    send_item(FUNC_FRESET, 16'd0, DEV_FRESET);
    send_item(FUNC_TICK, 16'd150, DEV_NOPOLL);
    send_item(FUNC_SET_STATE, 16'd0, DEV_FRESET);
    send_item(FUNC_TICK, 16'd50, DEV_NOPOLL);
    send_item(FUNC_UNUSED, 16'd0, DEV_NOPOLL);
    send_item(FUNC_TICK, 16'hFFFF, DEV_NOPOLL);

    for (ph = 1; ph <= NUM_PHASES; ph++) begin
      settle();
      set_phase(ph);
      if (ph == HOLD_PHASE)
        hold_req = 1'b1;
      repeat (PHASE_ITEMS) random_item();
    end
    settle();

    $display("covered %0d transactions over %0d register settings: %0d ticks, %0d state",
             n_tick + n_set + n_freset + n_unused, NUM_PHASES + 1, n_tick, n_set);
    $display("changes, %0d factory resets, %0d unused codes; %0d long output hold-off(s)",
             n_freset, n_unused, n_holds);
    if (outstanding != 0)
      $display("%0d expected results never returned", outstanding);
    if (errors == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("run timed out");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
